/* rtl/cdrad_pkg.sv */
// Shared types, codes and calendar tables for the date register.
// No dependencies; imported by calendar_date_register_add_days and tb.
package cdrad_pkg;

	// Operation carried in the tuser field of an input beat
	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_ADVANCE = 2'd1,
		MODE_COMPARE = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	// Compare outcome
	localparam logic [1:0] ORDER_EQUAL   = 2'd0;
	localparam logic [1:0] ORDER_LATER   = 2'd1;
	localparam logic [1:0] ORDER_EARLIER = 2'd2;

	// Configuration register indexes
	localparam logic REG_MIN_YEAR = 1'b0;
	localparam logic REG_MAX_YEAR = 1'b1;

	// Field widths
	localparam int unsigned MonthW = 4;
	localparam int unsigned DayW   = 5;
	localparam int unsigned YearW  = 14;
	localparam int unsigned CountW = 12;
	localparam int unsigned OrdW   = 9;

	// Reciprocal of 100: floor(y * 5243 / 2^19) == y / 100 for y below 43699
	localparam logic [12:0] RECIP_100 = 13'd5243;

	// Month length, 0 for codes that are no month
	function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic lp);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                  len = 5'd30;
			4'd2:                                       len = lp ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in the months before month m of a common year
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] sum;
		unique case (m)
			4'd2:    sum = 9'd31;
			4'd3:    sum = 9'd59;
			4'd4:    sum = 9'd90;
			4'd5:    sum = 9'd120;
			4'd6:    sum = 9'd151;
			4'd7:    sum = 9'd181;
			4'd8:    sum = 9'd212;
			4'd9:    sum = 9'd243;
			4'd10:   sum = 9'd273;
			4'd11:   sum = 9'd304;
			4'd12:   sum = 9'd334;
			default: sum = 9'd0;
		endcase
		return sum;
	endfunction

endpackage

/* rtl/calendar_date_register_add_days.sv */
// Calendar date register: load, advance by a day count, compare.
// Depends on cdrad_pkg (mode codes, month tables).
//
// Each beat runs the leap check (ST_LMUL, ST_LCHK), ST_EXEC for load and advance,
// then ST_OUT; a rejection re-runs the leap check. An advance steps by months, skips
// whole years from 1 January, ends with a partial month, redoes the leap check per year.
// One beat at a time: a leap-year unit (reciprocal multiply, then check) and a
// month/year stepper are reused; s_tready is high only while idle.
// A finished result waits in the output register while the next beat enters.
// Reset: date 1 January 2000, window (1899, 9999], no result pending.
module calendar_date_register_add_days (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // month_in[3:0], day_in[8:4], year_in[22:9], day_count[34:23]
	input  logic [1:0]  s_tuser,   // mode[1:0]
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // ok[0], order[2:1], month_out[6:3], day_out[11:7],
	                               // year_out[25:12], day_of_year[34:26]
	// configuration writes
	input  logic        cfg_wen,
	input  logic        cfg_addr,
	input  logic [13:0] cfg_wdata
);
	import cdrad_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LMUL,
		ST_LCHK,
		ST_EXEC,
		ST_OUT
	} state_t;

	state_t        state_q;
	mode_t         mode_q;
	logic [3:0]    in_month_q;
	logic [4:0]    in_day_q;
	logic [13:0]   in_year_q;
	logic [11:0]   rem_q;
	logic [3:0]    nm_q;
	logic [4:0]    nd_q;
	logic [14:0]   ny_q;
	logic [14:0]   wy_q;
	logic [8:0]    q_q;
	logic          leap_q;
	logic          final_q;
	logic          ok_q;
	logic [1:0]    order_q;
	logic [3:0]    cur_month_q;
	logic [4:0]    cur_day_q;
	logic [13:0]   cur_year_q;
	logic [13:0]   min_year_q;
	logic [13:0]   max_year_q;
	logic          out_valid_q;
	logic [39:0]   out_data_q;

	// input beat fields
	logic [3:0]    s_month;
	logic [4:0]    s_day;
	logic [13:0]   s_year;
	logic [11:0]   s_count;
	mode_t         s_mode;
	logic [1:0]    cmp_order;

	assign s_month = s_tdata[3:0];
	assign s_day   = s_tdata[8:4];
	assign s_year  = s_tdata[22:9];
	assign s_count = s_tdata[34:23];
	assign s_mode  = mode_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// raw ordering of the given date against the stored one
	always_comb begin
		priority if (s_year != cur_year_q) begin
			cmp_order = (s_year > cur_year_q) ? ORDER_LATER : ORDER_EARLIER;
		end else if (s_month != cur_month_q) begin
			cmp_order = (s_month > cur_month_q) ? ORDER_LATER : ORDER_EARLIER;
		end else if (s_day != cur_day_q) begin
			cmp_order = (s_day > cur_day_q) ? ORDER_LATER : ORDER_EARLIER;
		end else begin
			cmp_order = ORDER_EQUAL;
		end
	end

	// leap unit: quotient by 100 through reciprocal, then divisibility check
	logic [27:0]   recip_prod;
	logic [15:0]   hund;
	logic          leap_calc;

	assign recip_prod = 28'(wy_q) * 28'(RECIP_100);
	assign hund       = 16'({q_q, 6'b0}) + 16'({q_q, 5'b0}) + 16'({q_q, 2'b0});
	assign leap_calc  = (wy_q[1:0] == 2'b00) &&
	                    ((hund != 16'(wy_q)) || (q_q[1:0] == 2'b00));

	// load check
	logic [4:0]    load_len;
	logic          load_ok;

	assign load_len = days_in_month(in_month_q, leap_q);
	assign load_ok  = (load_len != 5'd0) && (in_day_q != 5'd0) && (in_day_q <= load_len) &&
	                  (in_year_q > min_year_q) && (in_year_q <= max_year_q);

	// month/year stepper
	logic [4:0]    walk_len;
	logic [4:0]    walk_left;
	logic [8:0]    year_len;
	logic          at_year_start;

	assign walk_len      = days_in_month(nm_q, leap_q);
	assign walk_left     = walk_len - nd_q;
	assign year_len      = leap_q ? 9'd366 : 9'd365;
	assign at_year_start = (nm_q == 4'd1) && (nd_q == 5'd1);

	// ordinal of the stored date
	logic [8:0]    ordinal;

	assign ordinal = days_before(cur_month_q) + 9'(cur_day_q) +
	                 9'(leap_q && (cur_month_q > 4'd2));

	// sequencer, date state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_NONE;
			in_month_q  <= '0;
			in_day_q    <= '0;
			in_year_q   <= '0;
			rem_q       <= '0;
			nm_q        <= 4'd1;
			nd_q        <= 5'd1;
			ny_q        <= '0;
			wy_q        <= '0;
			q_q         <= '0;
			leap_q      <= 1'b0;
			final_q     <= 1'b0;
			ok_q        <= 1'b0;
			order_q     <= ORDER_EQUAL;
			cur_month_q <= 4'd1;
			cur_day_q   <= 5'd1;
			cur_year_q  <= 14'd2000;
			min_year_q  <= 14'd1899;
			max_year_q  <= 14'd9999;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			// configuration writes
			if (cfg_wen) begin
				unique case (cfg_addr)
					REG_MIN_YEAR: min_year_q <= cfg_wdata;
					REG_MAX_YEAR: max_year_q <= cfg_wdata;
				endcase
			end

			// result taken; the output state reloads it on its own
			if (out_valid_q && m_tready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						mode_q     <= s_mode;
						in_month_q <= s_month;
						in_day_q   <= s_day;
						in_year_q  <= s_year;
						rem_q      <= s_count;
						nm_q       <= cur_month_q;
						nd_q       <= cur_day_q;
						ny_q       <= 15'(cur_year_q);
						ok_q       <= (s_mode == MODE_COMPARE);
						order_q    <= (s_mode == MODE_COMPARE) ? cmp_order : ORDER_EQUAL;
						wy_q       <= (s_mode == MODE_LOAD) ? 15'(s_year) : 15'(cur_year_q);
						final_q    <= (s_mode == MODE_COMPARE) || (s_mode == MODE_NONE);
						state_q    <= ST_LMUL;
					end
				end
				ST_LMUL: begin
					q_q     <= recip_prod[27:19];
					state_q <= ST_LCHK;
				end
				ST_LCHK: begin
					leap_q  <= leap_calc;
					state_q <= final_q ? ST_OUT : ST_EXEC;
				end
				ST_EXEC: begin
					if (mode_q == MODE_LOAD) begin
						if (load_ok) begin
							cur_month_q <= in_month_q;
							cur_day_q   <= in_day_q;
							cur_year_q  <= in_year_q;
							ok_q        <= 1'b1;
							state_q     <= ST_OUT;
						end else begin
							wy_q    <= 15'(cur_year_q);
							final_q <= 1'b1;
							state_q <= ST_LMUL;
						end
					end else if (rem_q == '0) begin
						// advance finished: commit if the year does not pass the window's upper bound
						if (ny_q <= 15'(max_year_q)) begin
							cur_month_q <= nm_q;
							cur_day_q   <= nd_q;
							cur_year_q  <= ny_q[13:0];
							ok_q        <= 1'b1;
							state_q     <= ST_OUT;
						end else begin
							wy_q    <= 15'(cur_year_q);
							final_q <= 1'b1;
							state_q <= ST_LMUL;
						end
					end else if (at_year_start && (12'(year_len) <= rem_q)) begin
						// skip a whole year
						rem_q   <= rem_q - 12'(year_len);
						ny_q    <= ny_q + 15'd1;
						wy_q    <= ny_q + 15'd1;
						state_q <= ST_LMUL;
					end else if (rem_q <= 12'(walk_left)) begin
						nd_q  <= nd_q + rem_q[4:0];
						rem_q <= '0;
					end else begin
						// step to the first of the next month
						rem_q <= rem_q - 12'(walk_left) - 12'd1;
						nd_q  <= 5'd1;
						if (nm_q == 4'd12) begin
							nm_q    <= 4'd1;
							ny_q    <= ny_q + 15'd1;
							wy_q    <= ny_q + 15'd1;
							state_q <= ST_LMUL;
						end else begin
							nm_q <= nm_q + 4'd1;
						end
					end
				end
				ST_OUT: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {5'd0, ordinal, cur_year_q, cur_day_q, cur_month_q,
						                order_q, ok_q};
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// stored date always has month 1 to 12 and a day within that month's leap-year length
	a_cur_date_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_month_q >= 4'd1) && (cur_month_q <= 4'd12) && (cur_day_q >= 5'd1) &&
		(cur_day_q <= days_in_month(cur_month_q, 1'b1)))
		else $error("stored date out of calendar range");

	// an accepted beat keeps the block busy for at least the leap check
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (!s_tready ##1 !s_tready))
		else $error("input accepted while previous beat in progress");

	// a pending result never shows an ordinal outside a year
	a_ordinal_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[34:26] >= 9'd1) && (m_tdata[34:26] <= 9'd366)))
		else $error("day of year out of range");

	// leaving the output state always posts a result
	a_out_posts: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_OUT) && (!out_valid_q || m_tready)) |=> (m_tvalid && s_tready))
		else $error("result not posted on completion");

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for calendar_date_register_add_days: loads, advances, compares and no-op beats.
// Depends on cdrad_pkg (mode and order codes, register indexes) and the block itself.
module tb;
	import cdrad_pkg::*;

	// Command and status records at the block's field widths
	typedef struct {
		mode_t       mode;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [13:0] year;
		logic [11:0] count;
	} date_cmd_t;

	typedef struct {
		logic        ok;
		logic [1:0]  order;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [13:0] year;
		logic [8:0]  doy;
	} date_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_wen = 1'b0;
	logic        cfg_addr = 1'b0;
	logic [13:0] cfg_wdata = '0;

	// Stimulus and scoreboard
	date_cmd_t    cmd_queue[$];
	date_status_t status_due[$];
	date_cmd_t    beat_cmd;
	date_status_t got_status;
	date_status_t want_status;
	int           cmds_queued = 0;
	int           results_seen = 0;
	int           mismatch_count = 0;
	int           send_idle_pct = 0;
	int           recv_idle_pct = 0;

	// Predictor state: stored date and year window
	int cal_month = 1;
	int cal_day = 1;
	int cal_year = 2000;
	int win_min = 1899;
	int win_max = 9999;

	// Generator's guess of the stored date, used to aim compares
	int aim_month = 1;
	int aim_day = 1;
	int aim_year = 2000;

	calendar_date_register_add_days dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Gregorian calendar helpers
	function automatic bit leap_year(int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int month_days(int m, int y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic int year_day(int m, int d, int y);
		int sum;
		sum = d;
		for (int i = 1; i < m && i <= 12; i++)
			sum += month_days(i, y);
		return sum;
	endfunction

	// Expected status for one accepted command; updates the predicted date
	function automatic date_status_t apply_cmd(date_cmd_t c);
		date_status_t st;
		int nm, nd, ny, rem, len, left;
		st.ok = 1'b0;
		st.order = ORDER_EQUAL;
		case (c.mode)
			MODE_LOAD: begin
				len = month_days(c.month, c.year);
				if (len != 0 && c.day >= 1 && c.day <= len &&
				    c.year > win_min && c.year <= win_max) begin
					cal_month = c.month;
					cal_day = c.day;
					cal_year = c.year;
					st.ok = 1'b1;
				end
			end
			MODE_ADVANCE: begin
				nm = cal_month;
				nd = cal_day;
				ny = cal_year;
				rem = c.count;
				// walk whole months until the rest fits in the current one
				while (rem > 0) begin
					len = month_days(nm, ny);
					left = (nd < len) ? len - nd : 0;
					if (rem <= left) begin
						nd += rem;
						rem = 0;
					end else begin
						rem -= left + 1;
						nd = 1;
						nm++;
						if (nm > 12) begin
							nm = 1;
							ny++;
						end
					end
				end
				if (ny <= win_max) begin
					cal_month = nm;
					cal_day = nd;
					cal_year = ny;
					st.ok = 1'b1;
				end
			end
			MODE_COMPARE: begin
				st.ok = 1'b1;
				if (c.year != cal_year)
					st.order = (c.year > cal_year) ? ORDER_LATER : ORDER_EARLIER;
				else if (c.month != cal_month)
					st.order = (c.month > cal_month) ? ORDER_LATER : ORDER_EARLIER;
				else if (c.day != cal_day)
					st.order = (c.day > cal_day) ? ORDER_LATER : ORDER_EARLIER;
			end
			default: ;
		endcase
		st.month = cal_month[3:0];
		st.day = cal_day[4:0];
		st.year = cal_year[13:0];
		st.doy = 9'(year_day(cal_month, cal_day, cal_year));
		return st;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	task automatic check_field(string what, int got, int want);
		if (got != want)
			report_mismatch(what, got, want);
	endtask

	task automatic queue_cmd(mode_t mode, int m, int d, int y, int cnt);
		date_cmd_t c;
		c.mode = mode;
		c.month = m[3:0];
		c.day = d[4:0];
		c.year = y[13:0];
		c.count = cnt[11:0];
		cmd_queue.push_back(c);
		cmds_queued++;
	endtask

	// Wait until every queued command has come back, then a short guard
	task automatic wait_idle();
		do
			@(posedge clk);
		while (results_seen != cmds_queued);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_window(logic idx, int value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value[13:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_MIN_YEAR)
			win_min = value;
		else
			win_max = value;
	endtask

	task automatic set_window(int lo, int hi);
		wait_idle();
		write_window(REG_MIN_YEAR, lo);
		write_window(REG_MAX_YEAR, hi);
	endtask

	// Random traffic: mostly valid loads, short advances and near-miss compares
	task automatic queue_random(int n);
		int pick, m, d, y, cnt, lo;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			m = $urandom_range(15);
			d = $urandom_range(31);
			y = $urandom_range(9999);
			cnt = $urandom_range(4095);
			if (pick < 30) begin
				if ($urandom_range(9) < 8) begin
					lo = win_min + 1;
					if (lo <= win_max)
						y = $urandom_range(win_max, lo);
					m = $urandom_range(12, 1);
					d = $urandom_range(month_days(m, y), 1);
					aim_month = m;
					aim_day = d;
					aim_year = y;
				end
				queue_cmd(MODE_LOAD, m, d, y, cnt);
			end else if (pick < 70) begin
				case ($urandom_range(9))
					0:       ;
					1, 2:    cnt = $urandom_range(400);
					default: cnt = $urandom_range(40);
				endcase
				queue_cmd(MODE_ADVANCE, m, d, y, cnt);
			end else if (pick < 95) begin
				m = aim_month;
				d = aim_day;
				y = aim_year;
				case ($urandom_range(3))
					1: y = y + $urandom_range(2) - 1;
					2: m = m + $urandom_range(2) - 1;
					3: d = d + $urandom_range(2) - 1;
					default: ;
				endcase
				if (y < 0)
					y = 0;
				if (y > 9999)
					y = 9999;
				queue_cmd(MODE_COMPARE, m, d, y, cnt);
			end else begin
				queue_cmd(MODE_NONE, m, d, y, cnt);
			end
		end
	endtask

	// Driver: present the next command; predict on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				status_due.push_back(apply_cmd(beat_cmd));
			if (!s_tvalid || s_tready) begin
				if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					beat_cmd = cmd_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= beat_cmd.mode;
					s_tdata <= {5'b0, beat_cmd.count, beat_cmd.year, beat_cmd.day,
					            beat_cmd.month};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result beat against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_status.ok = m_tdata[0];
				got_status.order = m_tdata[2:1];
				got_status.month = m_tdata[6:3];
				got_status.day = m_tdata[11:7];
				got_status.year = m_tdata[25:12];
				got_status.doy = m_tdata[34:26];
				if (status_due.size() == 0) begin
					report_mismatch("unexpected result beat, year", got_status.year, -1);
				end else begin
					want_status = status_due.pop_front();
					check_field("ok", got_status.ok, want_status.ok);
					check_field("order", got_status.order, want_status.order);
					check_field("month", got_status.month, want_status.month);
					check_field("day", got_status.day, want_status.day);
					check_field("year", got_status.year, want_status.year);
					check_field("day of year", got_status.doy, want_status.doy);
					results_seen++;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Main sequence
	initial begin
		send_idle_pct = 19;
		recv_idle_pct = 68;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: leap rules, bad fields, window edges, carries, compares
		queue_cmd(MODE_COMPARE, 1, 1, 2000, 0);
		queue_cmd(MODE_LOAD, 2, 29, 2000, 0);
		queue_cmd(MODE_LOAD, 2, 29, 1900, 0);
		queue_cmd(MODE_LOAD, 2, 29, 2100, 0);
		queue_cmd(MODE_LOAD, 2, 29, 2400, 0);
		queue_cmd(MODE_LOAD, 0, 10, 2000, 0);
		queue_cmd(MODE_LOAD, 13, 1, 2000, 0);
		queue_cmd(MODE_LOAD, 15, 31, 9999, 4095);
		queue_cmd(MODE_LOAD, 4, 31, 2001, 0);
		queue_cmd(MODE_LOAD, 5, 0, 2001, 0);
		queue_cmd(MODE_LOAD, 1, 1, 1899, 0);
		queue_cmd(MODE_LOAD, 1, 1, 0, 0);
		queue_cmd(MODE_LOAD, 1, 1, 1900, 0);
		queue_cmd(MODE_ADVANCE, 0, 0, 0, 0);
		queue_cmd(MODE_ADVANCE, 15, 31, 9999, 4095);
		queue_cmd(MODE_LOAD, 12, 31, 2000, 0);
		queue_cmd(MODE_ADVANCE, 0, 0, 0, 1);
		queue_cmd(MODE_COMPARE, 1, 1, 2002, 0);
		queue_cmd(MODE_COMPARE, 12, 31, 2000, 0);
		queue_cmd(MODE_LOAD, 12, 31, 9999, 0);
		queue_cmd(MODE_ADVANCE, 0, 0, 0, 0);
		queue_cmd(MODE_ADVANCE, 0, 0, 0, 1);
		queue_cmd(MODE_COMPARE, 12, 31, 9999, 0);
		queue_cmd(MODE_COMPARE, 1, 1, 9999, 0);
		queue_cmd(MODE_COMPARE, 15, 31, 9999, 0);
		queue_cmd(MODE_COMPARE, 12, 30, 9999, 0);
		queue_cmd(MODE_NONE, 15, 31, 9999, 4095);
		aim_month = 12;
		aim_day = 31;
		aim_year = 9999;

		// random phases across several windows, extremes included
		set_window(0, 9999);
		queue_random(200);
		set_window(1899, 2030);
		queue_random(200);
		wait_idle();
		send_idle_pct = 68;
		recv_idle_pct = 19;
		set_window(9999, 0);
		queue_random(100);
		set_window(1950, 2100);
		queue_random(250);
		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_window(1899, 9999);
		queue_random(250);
		set_window($urandom_range(2500), $urandom_range(9999, 2501));
		queue_random(200);

		wait_idle();
		repeat (80) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
rtl/cdrad_pkg.sv
rtl/calendar_date_register_add_days.sv
verif/tb.sv
